### rtl/dupire_local_volatility_defines.svh
// Assertion macros used by the local volatility top level.
`ifndef DUPIRE_LOCAL_VOLATILITY_DEFINES_SVH
`define DUPIRE_LOCAL_VOLATILITY_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define DLV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlv assertion failed");

// Next-cycle implication, also checked across reset.
`define DLV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dlv assertion failed");

`endif

### rtl/dlv_pkg.sv
// Types, constants and Q32.32 helper functions for the local volatility block.
`default_nettype none
package dlv_pkg;

  typedef logic signed [63:0] q_t;

  localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
  localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
  localparam q_t LN2_Q = 64'sd2977044472;

  localparam logic [62:0] SPOT_RST = 63'd4294967296;
  localparam logic [62:0] STEP_RST = 63'd42949673;

  // unit latencies in cycles
  localparam int LAT_MUL  = 2;
  localparam int LAT_DIV  = 98;
  localparam int LAT_SQRT = 48;
  localparam int LAT_LOG  = 66;

  typedef enum logic [1:0] {
    CFG_SPOT   = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_STEP_T = 2'd2,
    CFG_STEP_K = 2'd3
  } cfg_idx_t;

  function automatic q_t q_add(q_t a, q_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  // divide by two, rounding toward zero
  function automatic q_t q_half(q_t a);
    q_t h;
    h = a >>> 1;
    if (a[63] && a[0]) h = h + 64'sd1;
    return h;
  endfunction

  function automatic logic [63:0] mag(q_t a);
    return a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
  endfunction

  function automatic q_t q_sat(logic neg, logic [63:0] m, logic ovf);
    if (neg) begin
      if (ovf || m[63]) return Q_MIN;
      return q_t'(64'd0 - m);
    end
    if (ovf || m[63]) return Q_MAX;
    return q_t'(m);
  endfunction

endpackage
`default_nettype wire

### rtl/dupire_local_volatility.sv
// Top level: Dupire local volatility pipeline from five implied-volatility samples.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  in_      | input     | in_valid/in_stall  | maturity, strike, five vol samples
//  out_     | output    | out_valid/out_stall| local_vol, fell_back, bad_input
//  cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (64-bit)
//
//  One request is accepted per cycle while in_stall is low.
//  Latency is set by the chain of three dividers and the final square root.
//  A stalled output register freezes the whole pipeline; nothing is dropped or repeated.
//  rst_n clears valid bits and loads config defaults; payload registers are not reset.
//  cfg_ready is always high; config registers are written in the cycle after cfg_valid.
`default_nettype none
`include "dupire_local_volatility_defines.svh"
module dupire_local_volatility (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [62:0]          in_maturity,
  input  logic [62:0]          in_strike,
  input  logic [62:0]          in_vol_center,
  input  logic [62:0]          in_vol_later,
  input  logic [62:0]          in_vol_earlier,
  input  logic [62:0]          in_vol_higher_strike,
  input  logic [62:0]          in_vol_lower_strike,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [62:0]          out_local_vol,
  output logic                 out_fell_back,
  output logic                 out_bad_input,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  dlv_pkg::cfg_idx_t    cfg_index,
  input  logic [63:0]          cfg_data
);
  import dlv_pkg::*;

  localparam int TM    = LAT_MUL;
  localparam int TD    = LAT_DIV;
  localparam int T_SS  = TM;
  localparam int T_XT  = 2 * TM;
  localparam int T_SQT = LAT_SQRT;
  localparam int T_SSQ = T_SQT + TM;
  localparam int T_KS  = T_SQT + TM;
  localparam int T_LN  = LAT_LOG + TM;
  localparam int T_DK  = TD;
  localparam int T_RDK = TD + TM;
  localparam int T_NUM = TD + 2 * TM;
  localparam int T_KDS = T_NUM;
  localparam int T_D2K = 2 * TD;
  localparam int T_KD2 = 2 * TD + 2 * TM;
  localparam int T_D1  = T_LN + TD;
  localparam int T_DEN = T_KD2 + TM;
  localparam int T_SSN = T_NUM + TM;
  localparam int T_OUT = T_DEN + TD + LAT_SQRT;

  // configuration
  logic [62:0] spot_r, stept_r, stepk_r;
  q_t          rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r  <= SPOT_RST;
      rate_r  <= '0;
      stept_r <= STEP_RST;
      stepk_r <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPOT:   spot_r  <= cfg_data[62:0];
        CFG_RATE:   rate_r  <= q_t'(cfg_data);
        CFG_STEP_T: stept_r <= cfg_data[62:0];
        CFG_STEP_K: stepk_r <= cfg_data[62:0];
        default:    ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic adv;
  logic vld_r [T_OUT];
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < T_OUT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < T_OUT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // request operands
  q_t t0, k0, s0, et, ek;
  q_t a_dt, a_dk, a_d3, a_ts;
  logic bad0;

  assign t0   = q_t'({1'b0, in_maturity});
  assign k0   = q_t'({1'b0, in_strike});
  assign s0   = q_t'({1'b0, in_vol_center});
  assign et   = q_t'({1'b0, stept_r});
  assign ek   = q_t'({1'b0, stepk_r});
  assign a_dt = q_t'({1'b0, in_vol_later}) - q_t'({1'b0, in_vol_earlier});
  assign a_dk = q_t'({1'b0, in_vol_higher_strike}) - q_t'({1'b0, in_vol_lower_strike});
  assign a_d3 = q_add(q_t'({1'b0, in_vol_higher_strike}) - s0,
                      q_t'({1'b0, in_vol_lower_strike}) - s0);
  assign a_ts = q_add(t0, t0);
  assign bad0 = (in_maturity == '0) || (in_strike == '0) || (in_vol_center == '0);

  // derivatives
  q_t dtq, dkq, d3q, d2k, ts, dt, dk;

  dlv_div u_dv_dt  (.clk, .en(adv), .a(a_dt), .b(et), .q(dtq));
  dlv_div u_dv_dk  (.clk, .en(adv), .a(a_dk), .b(ek), .q(dkq));
  dlv_div u_dv_d3  (.clk, .en(adv), .a(a_d3), .b(ek), .q(d3q));
  dlv_div u_dv_d2k (.clk, .en(adv), .a(d3q),  .b(ek), .q(d2k));
  dlv_div u_dv_ts  (.clk, .en(adv), .a(a_ts), .b(s0), .q(ts));

  assign dt = q_half(dtq);
  assign dk = q_half(dkq);

  // sqrt(T) and logs
  logic [47:0] sqt_root;
  q_t          sqt, lg_s, lg_k, ln_s, ln_k;

  dlv_sqrt u_sq_t (.clk, .en(adv), .x(t0), .root(sqt_root));
  assign sqt = q_t'({16'd0, sqt_root});

  dlv_ln u_ln_s (.clk, .en(adv), .x(spot_r),    .lg(lg_s));
  dlv_ln u_ln_k (.clk, .en(adv), .x(in_strike), .lg(lg_k));
  dlv_mul u_m_lns (.clk, .en(adv), .a(lg_s), .b(LN2_Q), .p(ln_s));
  dlv_mul u_m_lnk (.clk, .en(adv), .a(lg_k), .b(LN2_Q), .p(ln_k));

  // d1 numerator
  q_t ss, x2, t_ss, xt, xt_ln, s_sqt, ssq, ssq_ln, ssq_d1, d1n, d1, d2;

  dlv_mul u_m_ss (.clk, .en(adv), .a(s0), .b(s0), .p(ss));
  dlv_dly #(.W(64), .N(T_SS)) u_dl_t (.clk, .en(adv), .d(t0), .q(t_ss));
  assign x2 = q_add(rate_r, q_half(ss));
  dlv_mul u_m_xt (.clk, .en(adv), .a(x2), .b(t_ss), .p(xt));
  dlv_dly #(.W(64), .N(T_LN - T_XT)) u_dl_xt (.clk, .en(adv), .d(xt), .q(xt_ln));

  dlv_dly #(.W(64), .N(T_SQT)) u_dl_s (.clk, .en(adv), .d(s0), .q(s_sqt));
  dlv_mul u_m_ssq (.clk, .en(adv), .a(s_sqt), .b(sqt), .p(ssq));
  dlv_dly #(.W(64), .N(T_LN - T_SSQ)) u_dl_ssq (.clk, .en(adv), .d(ssq), .q(ssq_ln));
  dlv_dly #(.W(64), .N(T_D1 - T_LN)) u_dl_ssq2 (.clk, .en(adv), .d(ssq_ln), .q(ssq_d1));

  assign d1n = q_add(q_sub(ln_s, ln_k), xt_ln);
  dlv_div u_dv_d1 (.clk, .en(adv), .a(d1n), .b(ssq_ln), .q(d1));
  assign d2 = q_sub(d1, ssq_d1);

  // numerator
  q_t rdk, dt_rdk, ts_rdk, numm, num;

  dlv_mul u_m_rdk (.clk, .en(adv), .a(rate_r), .b(dk), .p(rdk));
  dlv_dly #(.W(64), .N(T_RDK - T_DK)) u_dl_dt (.clk, .en(adv), .d(dt), .q(dt_rdk));
  dlv_dly #(.W(64), .N(T_RDK - T_DK)) u_dl_ts (.clk, .en(adv), .d(ts), .q(ts_rdk));
  dlv_mul u_m_num (.clk, .en(adv), .a(ts_rdk), .b(q_add(dt_rdk, rdk)), .p(numm));
  assign num = q_add(Q_ONE, numm);

  // strike-scaled terms
  q_t k_dk, kdk, sqt_rdk, kds, ks0, ks_sqt, ks, k_d2k, kd2a, sqt_kd2, kd2;

  dlv_dly #(.W(64), .N(T_DK)) u_dl_k (.clk, .en(adv), .d(k0), .q(k_dk));
  dlv_mul u_m_kdk (.clk, .en(adv), .a(k_dk), .b(dk), .p(kdk));
  dlv_dly #(.W(64), .N(T_RDK - T_SQT)) u_dl_sqt (.clk, .en(adv), .d(sqt), .q(sqt_rdk));
  dlv_mul u_m_kds (.clk, .en(adv), .a(kdk), .b(sqt_rdk), .p(kds));

  dlv_mul u_m_ks0 (.clk, .en(adv), .a(k0), .b(s0), .p(ks0));
  dlv_dly #(.W(64), .N(T_SQT - T_SS)) u_dl_ks0 (.clk, .en(adv), .d(ks0), .q(ks_sqt));
  dlv_mul u_m_ks (.clk, .en(adv), .a(ks_sqt), .b(sqt), .p(ks));

  dlv_dly #(.W(64), .N(T_D2K - T_DK)) u_dl_k2 (.clk, .en(adv), .d(k_dk), .q(k_d2k));
  dlv_mul u_m_kd2a (.clk, .en(adv), .a(k_d2k), .b(d2k), .p(kd2a));
  dlv_dly #(.W(64), .N(T_D2K + TM - T_RDK)) u_dl_sqt2 (
    .clk, .en(adv), .d(sqt_rdk), .q(sqt_kd2));
  dlv_mul u_m_kd2 (.clk, .en(adv), .a(kd2a), .b(sqt_kd2), .p(kd2));

  // denominator
  q_t kds_d1, kds_t1, kds_t2, t1, dd, t3a, t3, ks_kd2, t4, t1_den, t3_den, den;

  dlv_dly #(.W(64), .N(T_D1 - T_KDS)) u_dl_kds (.clk, .en(adv), .d(kds), .q(kds_d1));
  dlv_dly #(.W(64), .N(TM)) u_dl_kds1 (.clk, .en(adv), .d(kds_d1), .q(kds_t1));
  dlv_dly #(.W(64), .N(TM)) u_dl_kds2 (.clk, .en(adv), .d(kds_t1), .q(kds_t2));

  dlv_mul u_m_t1  (.clk, .en(adv), .a(q_add(d1, d1)), .b(kds_d1), .p(t1));
  dlv_mul u_m_dd  (.clk, .en(adv), .a(d1),  .b(d2),     .p(dd));
  dlv_mul u_m_t3a (.clk, .en(adv), .a(dd),  .b(kds_t1), .p(t3a));
  dlv_mul u_m_t3  (.clk, .en(adv), .a(t3a), .b(kds_t2), .p(t3));

  dlv_dly #(.W(64), .N(T_KD2 - T_KS)) u_dl_ks (.clk, .en(adv), .d(ks), .q(ks_kd2));
  dlv_mul u_m_t4 (.clk, .en(adv), .a(kd2), .b(ks_kd2), .p(t4));

  dlv_dly #(.W(64), .N(T_DEN - T_D1 - TM)) u_dl_t1 (.clk, .en(adv), .d(t1), .q(t1_den));
  dlv_dly #(.W(64), .N(T_DEN - T_D1 - 3 * TM)) u_dl_t3 (
    .clk, .en(adv), .d(t3), .q(t3_den));

  assign den = q_add(q_add(q_add(Q_ONE, t1_den), t3_den), t4);

  // variance and result
  q_t ss_num, ssn, ssn_den, num_den, var_q;
  logic neg_den, neg_out, bad_out;
  logic [62:0] s_out;
  logic [47:0] lv_root;

  dlv_dly #(.W(64), .N(T_NUM - T_SS)) u_dl_ss (.clk, .en(adv), .d(ss), .q(ss_num));
  dlv_mul u_m_ssn (.clk, .en(adv), .a(ss_num), .b(num), .p(ssn));
  dlv_dly #(.W(64), .N(T_DEN - T_SSN)) u_dl_ssn (.clk, .en(adv), .d(ssn), .q(ssn_den));
  dlv_dly #(.W(64), .N(T_DEN - T_NUM)) u_dl_num (.clk, .en(adv), .d(num), .q(num_den));

  assign neg_den = den[63] || num_den[63];

  dlv_div u_dv_var (.clk, .en(adv), .a(ssn_den), .b(den), .q(var_q));
  dlv_sqrt u_sq_v (.clk, .en(adv), .x(var_q), .root(lv_root));

  dlv_dly #(.W(1), .N(T_OUT - T_DEN)) u_dl_neg (.clk, .en(adv), .d(neg_den), .q(neg_out));
  dlv_dly #(.W(63), .N(T_OUT - T_SQT)) u_dl_sc (
    .clk, .en(adv), .d(s_sqt[62:0]), .q(s_out));
  dlv_dly #(.W(1), .N(T_OUT)) u_dl_bad (.clk, .en(adv), .d(bad0), .q(bad_out));

  // output register
  logic [62:0] lv_nxt, out_lv_r;
  logic        fb_nxt, bi_nxt, out_fb_r, out_bi_r;

  always_comb begin
    priority if (bad_out) begin
      lv_nxt = '0;
      fb_nxt = 1'b0;
      bi_nxt = 1'b1;
    end else if (neg_out) begin
      lv_nxt = s_out;
      fb_nxt = 1'b1;
      bi_nxt = 1'b0;
    end else begin
      lv_nxt = {15'd0, lv_root};
      fb_nxt = 1'b0;
      bi_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[T_OUT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lv_r <= lv_nxt;
      out_fb_r <= fb_nxt;
      out_bi_r <= bi_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_local_vol = out_lv_r;
  assign out_fell_back = out_fb_r;
  assign out_bad_input = out_bi_r;

  `DLV_ASSERT_IMP(a_flags_excl, out_valid_r, !(out_fell_back && out_bad_input))
  `DLV_ASSERT_IMP(a_bad_zero, out_valid_r && out_bad_input, out_local_vol == '0)
  `DLV_ASSERT_IMP(a_fb_nonzero, out_valid_r && out_fell_back, out_local_vol != '0)
  `DLV_ASSERT_NXT(a_rst_clear, !rst_n, !out_valid_r)

endmodule
`default_nettype wire

### rtl/dlv_dly.sv
// Enabled delay line used to align operands between pipeline units.
`default_nettype none
module dlv_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < N; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[N-1];

endmodule
`default_nettype wire

### rtl/dlv_mul.sv
// Two-stage saturating Q32.32 multiplier built from 32x32 partial products.
`default_nettype none
module dlv_mul (
  input  logic          clk,
  input  logic          en,
  input  dlv_pkg::q_t   a,
  input  dlv_pkg::q_t   b,
  output dlv_pkg::q_t   p
);
  import dlv_pkg::*;

  logic [63:0]  ma, mb;
  logic         neg_r;
  logic [63:0]  pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [127:0] prod;
  q_t           p_r;

  assign ma = mag(a);
  assign mb = mag(b);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r   <= a[63] ^ b[63];
      pp_ll_r <= 64'(ma[31:0])  * 64'(mb[31:0]);
      pp_lh_r <= 64'(ma[31:0])  * 64'(mb[63:32]);
      pp_hl_r <= 64'(ma[63:32]) * 64'(mb[31:0]);
      pp_hh_r <= 64'(ma[63:32]) * 64'(mb[63:32]);
    end
  end

  assign prod = {pp_hh_r, 64'd0} + ({64'd0, pp_lh_r} << 32) + ({64'd0, pp_hl_r} << 32)
              + {64'd0, pp_ll_r};

  always_ff @(posedge clk) begin
    if (en) p_r <= q_sat(neg_r, prod[95:32], |prod[127:96]);
  end

  assign p = p_r;

endmodule
`default_nettype wire

### rtl/dlv_div.sv
// Pipelined Q32.32 divider: one quotient bit per stage, saturating result.
`default_nettype none
module dlv_div (
  input  logic          clk,
  input  logic          en,
  input  dlv_pkg::q_t   a,
  input  dlv_pkg::q_t   b,
  output dlv_pkg::q_t   q
);
  import dlv_pkg::*;

  localparam int NB = 96;

  typedef struct packed {
    logic neg;
    logic bzero;
    logic apos;
    logic aneg;
  } dflag_t;

  logic [63:0] num_r [NB+1];
  logic [63:0] den_r [NB+1];
  logic [63:0] rem_r [NB+1];
  logic [63:0] quo_r [NB+1];
  logic        ovf_r [NB+1];
  dflag_t      flg_r [NB+1];
  logic [63:0] rem_nxt [NB+1];
  logic [63:0] quo_nxt [NB+1];
  logic        ovf_nxt [NB+1];
  logic [NB:1] bitv;
  q_t          q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]       <= mag(a);
      den_r[0]       <= mag(b);
      rem_r[0]       <= '0;
      quo_r[0]       <= '0;
      ovf_r[0]       <= 1'b0;
      flg_r[0].neg   <= a[63] ^ b[63];
      flg_r[0].bzero <= (b == '0);
      flg_r[0].apos  <= !a[63] && (a != '0);
      flg_r[0].aneg  <= a[63];
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_stage
    localparam int I = NB - k;
    if (I >= 32) begin : g_bit
      assign bitv[k] = num_r[k-1][I-32];
    end else begin : g_zero
      assign bitv[k] = 1'b0;
    end

    always_comb begin
      logic [64:0] rs;
      logic        ge;
      rs = {rem_r[k-1], bitv[k]};
      ge = (rs >= {1'b0, den_r[k-1]});
      rem_nxt[k] = ge ? 64'(rs - {1'b0, den_r[k-1]}) : rs[63:0];
      quo_nxt[k] = {quo_r[k-1][62:0], ge};
      ovf_nxt[k] = ovf_r[k-1] | quo_r[k-1][63];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_r[k-1];
        den_r[k] <= den_r[k-1];
        flg_r[k] <= flg_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_r[NB].bzero) begin
        q_r <= flg_r[NB].apos ? Q_MAX : (flg_r[NB].aneg ? Q_MIN : '0);
      end else begin
        q_r <= q_sat(flg_r[NB].neg, quo_r[NB], ovf_r[NB]);
      end
    end
  end

  assign q = q_r;

  // stage zero holds unused next-value slots
  assign rem_nxt[0] = '0;
  assign quo_nxt[0] = '0;
  assign ovf_nxt[0] = 1'b0;

endmodule
`default_nettype wire

### rtl/dlv_sqrt.sv
// Pipelined square root: floor(sqrt(x * 2^32)), two radicand bits per stage.
`default_nettype none
module dlv_sqrt (
  input  logic          clk,
  input  logic          en,
  input  dlv_pkg::q_t   x,
  output logic [47:0]   root
);
  import dlv_pkg::*;

  localparam int NS = 48;

  logic [95:0] rad_i   [NS];
  logic [49:0] rem_i   [NS];
  logic [47:0] root_i  [NS];
  logic [95:0] rad_r   [NS];
  logic [49:0] rem_r   [NS];
  logic [47:0] root_r  [NS];
  logic [49:0] rem_nxt [NS];
  logic [47:0] root_nxt[NS];

  // non-positive input gives a zero radicand
  assign rad_i[0]  = (!x[63] && x != '0) ? {x[63:0], 32'd0} : 96'd0;
  assign rem_i[0]  = '0;
  assign root_i[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign rad_i[k]  = rad_r[k-1];
      assign rem_i[k]  = rem_r[k-1];
      assign root_i[k] = root_r[k-1];
    end

    always_comb begin
      logic [51:0] rs;
      logic [51:0] trial;
      logic        ge;
      rs    = {rem_i[k], rad_i[k][95-2*k -: 2]};
      trial = {2'b00, root_i[k], 2'b01};
      ge    = (rs >= trial);
      rem_nxt[k]  = ge ? 50'(rs - trial) : rs[49:0];
      root_nxt[k] = {root_i[k][46:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_i[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[NS-1];

endmodule
`default_nettype wire

### rtl/dlv_ln.sv
// Pipelined log2 in Q32.32: normalize, then 32 square-and-compare steps.
`default_nettype none
module dlv_ln (
  input  logic          clk,
  input  logic          en,
  input  logic [62:0]   x,
  output dlv_pkg::q_t   lg
);
  import dlv_pkg::*;

  localparam int NI = 32;

  logic [62:0] xx;
  logic [5:0]  p_enc;
  logic [62:0] xa_r;
  logic [5:0]  pa_r;

  logic [63:0] z_r   [NI+1];
  logic [31:0] f_r   [NI+1];
  logic [5:0]  p_r   [NI+1];
  logic [63:0] pll_r [NI];
  logic [63:0] plh_r [NI];
  logic [63:0] phh_r [NI];
  logic [31:0] f1_r  [NI];
  logic [5:0]  p1_r  [NI];
  logic [63:0] z_nxt [NI];
  logic [31:0] f_nxt [NI];
  logic signed [6:0] pe;

  always_comb begin
    xx    = (x == '0) ? 63'd1 : x;
    p_enc = '0;
    for (int i = 0; i < 63; i++) begin
      if (xx[i]) p_enc = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r   <= xx;
      pa_r   <= p_enc;
      z_r[0] <= {1'b0, xa_r} << (6'd62 - pa_r);
      p_r[0] <= pa_r;
      f_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < NI; j++) begin : g_iter
    localparam logic [31:0] FBIT = 32'd1 << (NI - 1 - j);

    always_ff @(posedge clk) begin
      if (en) begin
        pll_r[j] <= 64'(z_r[j][31:0])  * 64'(z_r[j][31:0]);
        plh_r[j] <= 64'(z_r[j][31:0])  * 64'(z_r[j][63:32]);
        phh_r[j] <= 64'(z_r[j][63:32]) * 64'(z_r[j][63:32]);
        f1_r[j]  <= f_r[j];
        p1_r[j]  <= p_r[j];
      end
    end

    always_comb begin
      logic [127:0] sq;
      logic [63:0]  zs;
      sq = {phh_r[j], 64'd0} + ({64'd0, plh_r[j]} << 33) + {64'd0, pll_r[j]};
      zs = sq[125:62];
      // reaching two halves the mantissa and sets this fraction bit
      z_nxt[j] = zs[63] ? (zs >> 1) : zs;
      f_nxt[j] = zs[63] ? (f1_r[j] | FBIT) : f1_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[j+1] <= z_nxt[j];
        f_r[j+1] <= f_nxt[j];
        p_r[j+1] <= p1_r[j];
      end
    end
  end

  assign pe = $signed({1'b0, p_r[NI]}) - 7'sd32;
  assign lg = {{25{pe[6]}}, pe, f_r[NI]};

endmodule
`default_nettype wire
